// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on the rising edge and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define CHK_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant check failed");

// consequent must hold in the same cycle as the antecedent
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`endif

// ===== hdl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// types and constants shared by the command line tokenizer modules
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int MAX_TOKENS_DEF = 32;
  localparam int MAX_LINE_DEF   = 4096;

  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int RES_MAX = 3;
  localparam int RES_IDX_W = $clog2(RES_MAX);
  localparam int RES_CNT_W = $clog2(RES_MAX + 1);

  // result group queue between lexer and issue stage
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_QUOTED  = 3'd1,
    KIND_PIPE    = 3'd2,
    KIND_IN      = 3'd3,
    KIND_OUT     = 3'd4,
    KIND_HEREDOC = 3'd5,
    KIND_APPEND  = 3'd6,
    KIND_NONE    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SYNTAX = 2'd1,
    ERR_TOKENS = 2'd2,
    ERR_LONG   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_QUOTE  = 2'd1,
    MODE_ERROR  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    RED_NONE = 2'd0,
    RED_IN   = 2'd1,
    RED_OUT  = 2'd2
  } redir_t;

  typedef struct packed {
    kind_t              kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    err_t               err;
    logic               line_done;
    logic               last_of_run;
  } res_t;

  // all results caused by one input item, a byte or an end of line
  typedef struct packed {
    res_t [RES_MAX-1:0]   res;
    logic [RES_CNT_W-1:0] cnt;
  } bundle_t;

endpackage

// ===== hdl/slt_front.sv =====
// ----------------------------------------------------------------------------
// slt_front
// lexer front: classifies each byte, updates line state, builds result group
// ----------------------------------------------------------------------------
module slt_front #(
  parameter int MAX_TOKENS = slt_pkg::MAX_TOKENS_DEF,
  parameter int MAX_LINE   = slt_pkg::MAX_LINE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take_i,
  input  logic [7:0]       character_i,
  input  logic             end_of_line_i,
  output logic             push_o,
  output slt_pkg::bundle_t bundle_o
);

  localparam int PW = $clog2(MAX_LINE + 1);
  localparam int CW = $clog2(MAX_TOKENS + 1);
  localparam int SW = slt_pkg::START_W;
  localparam int LW = slt_pkg::LEN_W;
  localparam int NW = slt_pkg::RES_CNT_W;
  localparam int IW = slt_pkg::RES_IDX_W;

  typedef struct packed {
    logic [PW-1:0]                   pos;
    logic [PW-1:0]                   tb;
    slt_pkg::mode_t                  mode;
    logic                            qd;
    slt_pkg::redir_t                 pr;
    slt_pkg::kind_t                  pk;
    logic [CW-1:0]                   tc;
    slt_pkg::err_t                   lerr;
    logic [NW-1:0]                   n;
    slt_pkg::res_t [slt_pkg::RES_MAX-1:0] res;
  } st_t;

  logic [PW-1:0]   pos_r, tb_r;
  slt_pkg::mode_t  mode_r;
  logic            qd_r;
  slt_pkg::redir_t pr_r;
  slt_pkg::kind_t  pk_r;
  logic [CW-1:0]   tc_r;
  slt_pkg::err_t   lerr_r;
  st_t             s_nxt;

  function automatic st_t f_put(st_t s, slt_pkg::kind_t k, logic [PW-1:0] start,
                                logic [PW-1:0] len, slt_pkg::err_t e);
    st_t r;
    r = s;
    if (r.n < NW'(slt_pkg::RES_MAX)) begin
      r.res[IW'(r.n)].kind        = k;
      r.res[IW'(r.n)].start       = SW'(start);
      r.res[IW'(r.n)].len         = LW'(len);
      r.res[IW'(r.n)].err         = e;
      r.res[IW'(r.n)].line_done   = 1'b0;
      r.res[IW'(r.n)].last_of_run = 1'b0;
      r.n = r.n + NW'(1);
    end
    return r;
  endfunction

  function automatic st_t f_fail(st_t s, slt_pkg::err_t e);
    st_t r;
    r = f_put(s, slt_pkg::KIND_NONE, '0, '0, e);
    r.mode = slt_pkg::MODE_ERROR;
    r.lerr = e;
    return r;
  endfunction

  function automatic st_t f_emit(st_t s, slt_pkg::kind_t k, logic [PW-1:0] start,
                                 logic [PW-1:0] len);
    st_t r;
    if (s.tc >= CW'(MAX_TOKENS)) begin
      r = f_fail(s, slt_pkg::ERR_TOKENS);
    end else begin
      r = f_put(s, k, start, len, slt_pkg::ERR_NONE);
      r.tc = s.tc + CW'(1);
      r.pk = k;
    end
    return r;
  endfunction

  function automatic st_t f_flush(st_t s);
    st_t r;
    r = s;
    if (s.pos > s.tb) begin
      r = f_emit(s, slt_pkg::KIND_WORD, s.tb, s.pos - s.tb);
    end
    return r;
  endfunction

  function automatic logic f_is_redir(slt_pkg::kind_t k);
    return (k == slt_pkg::KIND_IN) || (k == slt_pkg::KIND_OUT) ||
           (k == slt_pkg::KIND_HEREDOC) || (k == slt_pkg::KIND_APPEND);
  endfunction

  // normal mode with no redirect waiting
  function automatic st_t f_take_byte(st_t s, logic [7:0] c);
    st_t r;
    r = s;
    if (c == slt_pkg::CH_SPACE) begin
      r = f_flush(r);
      if (r.mode != slt_pkg::MODE_ERROR) r.tb = r.pos + PW'(1);
    end else if (c == slt_pkg::CH_PIPE) begin
      r = f_flush(r);
      if (r.mode != slt_pkg::MODE_ERROR) begin
        if (r.pk == slt_pkg::KIND_NONE || r.pk == slt_pkg::KIND_PIPE ||
            r.pk == slt_pkg::KIND_IN || r.pk == slt_pkg::KIND_HEREDOC) begin
          r = f_fail(r, slt_pkg::ERR_SYNTAX);
        end else begin
          r = f_emit(r, slt_pkg::KIND_PIPE, r.pos, PW'(1));
          if (r.mode != slt_pkg::MODE_ERROR) r.tb = r.pos + PW'(1);
        end
      end
    end else if (c == slt_pkg::CH_SQUOTE || c == slt_pkg::CH_DQUOTE) begin
      r.mode = slt_pkg::MODE_QUOTE;
      r.qd   = (c == slt_pkg::CH_DQUOTE);
    end else if (c == slt_pkg::CH_LT || c == slt_pkg::CH_GT) begin
      r = f_flush(r);
      if (r.mode != slt_pkg::MODE_ERROR) begin
        if (f_is_redir(r.pk)) begin
          r = f_fail(r, slt_pkg::ERR_SYNTAX);
        end else begin
          r.pr = (c == slt_pkg::CH_LT) ? slt_pkg::RED_IN : slt_pkg::RED_OUT;
          r.tb = r.pos;
        end
      end
    end
    return r;
  endfunction

  function automatic st_t f_take_char(st_t s, logic [7:0] c);
    st_t  r;
    logic red_in;
    r = s;
    red_in = (s.pr == slt_pkg::RED_IN);
    if (s.mode == slt_pkg::MODE_ERROR) begin
      r = s;
    end else if (s.pos >= PW'(MAX_LINE)) begin
      r = f_fail(s, slt_pkg::ERR_LONG);
    end else begin
      if (s.mode == slt_pkg::MODE_QUOTE) begin
        if (c == (s.qd ? slt_pkg::CH_DQUOTE : slt_pkg::CH_SQUOTE)) begin
          r = f_emit(r, slt_pkg::KIND_QUOTED, s.tb, s.pos + PW'(1) - s.tb);
          if (r.mode != slt_pkg::MODE_ERROR) begin
            r.mode = slt_pkg::MODE_NORMAL;
            r.tb   = s.pos + PW'(1);
          end
        end
      end else if (s.pr != slt_pkg::RED_NONE) begin
        r.pr = slt_pkg::RED_NONE;
        if (c == (red_in ? slt_pkg::CH_LT : slt_pkg::CH_GT)) begin
          r = f_emit(r, red_in ? slt_pkg::KIND_HEREDOC : slt_pkg::KIND_APPEND,
                     s.tb, PW'(2));
          if (r.mode != slt_pkg::MODE_ERROR) r.tb = s.pos + PW'(1);
        end else begin
          r = f_emit(r, red_in ? slt_pkg::KIND_IN : slt_pkg::KIND_OUT, s.tb, PW'(1));
          if (r.mode != slt_pkg::MODE_ERROR) begin
            r.tb = s.pos;
            r = f_take_byte(r, c);
          end
        end
      end else begin
        r = f_take_byte(r, c);
      end
      r.pos = s.pos + PW'(1);
    end
    return r;
  endfunction

  function automatic st_t f_end_line(st_t s);
    st_t r;
    r = s;
    if (s.mode == slt_pkg::MODE_ERROR) begin
      r = f_put(s, slt_pkg::KIND_NONE, '0, '0, s.lerr);
    end else if (s.mode == slt_pkg::MODE_QUOTE) begin
      r = f_fail(s, slt_pkg::ERR_SYNTAX);
    end else begin
      if (s.pr != slt_pkg::RED_NONE) begin
        r.pr = slt_pkg::RED_NONE;
        r = f_emit(r, (s.pr == slt_pkg::RED_IN) ? slt_pkg::KIND_IN : slt_pkg::KIND_OUT,
                   s.tb, PW'(1));
      end else begin
        r = f_flush(r);
      end
      if (r.mode != slt_pkg::MODE_ERROR &&
          (r.pk == slt_pkg::KIND_PIPE || f_is_redir(r.pk))) begin
        r = f_fail(r, slt_pkg::ERR_SYNTAX);
      end
    end
    // empty line still reports once
    if (r.n == NW'(0)) r = f_put(r, slt_pkg::KIND_NONE, '0, '0, slt_pkg::ERR_NONE);
    r.res[IW'(r.n - NW'(1))].line_done = 1'b1;
    r.pos  = '0;
    r.tb   = '0;
    r.mode = slt_pkg::MODE_NORMAL;
    r.qd   = 1'b0;
    r.pr   = slt_pkg::RED_NONE;
    r.pk   = slt_pkg::KIND_NONE;
    r.tc   = '0;
    r.lerr = slt_pkg::ERR_NONE;
    return r;
  endfunction

  always_comb begin
    st_t cur;
    cur      = '0;
    cur.pos  = pos_r;
    cur.tb   = tb_r;
    cur.mode = mode_r;
    cur.qd   = qd_r;
    cur.pr   = pr_r;
    cur.pk   = pk_r;
    cur.tc   = tc_r;
    cur.lerr = lerr_r;
    cur.n    = '0;
    for (int i = 0; i < slt_pkg::RES_MAX; i++) begin
      cur.res[i].kind = slt_pkg::KIND_NONE;
      cur.res[i].err  = slt_pkg::ERR_NONE;
    end
    if (end_of_line_i) begin
      s_nxt = f_end_line(cur);
    end else begin
      s_nxt = f_take_char(cur, character_i);
    end
    if (s_nxt.n != NW'(0)) s_nxt.res[IW'(s_nxt.n - NW'(1))].last_of_run = 1'b1;
  end

  assign push_o       = take_i && (s_nxt.n != NW'(0));
  assign bundle_o.res = s_nxt.res;
  assign bundle_o.cnt = s_nxt.n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tb_r   <= '0;
      mode_r <= slt_pkg::MODE_NORMAL;
      qd_r   <= 1'b0;
      pr_r   <= slt_pkg::RED_NONE;
      pk_r   <= slt_pkg::KIND_NONE;
      tc_r   <= '0;
      lerr_r <= slt_pkg::ERR_NONE;
    end else if (take_i) begin
      pos_r  <= s_nxt.pos;
      tb_r   <= s_nxt.tb;
      mode_r <= s_nxt.mode;
      qd_r   <= s_nxt.qd;
      pr_r   <= s_nxt.pr;
      pk_r   <= s_nxt.pk;
      tc_r   <= s_nxt.tc;
      lerr_r <= s_nxt.lerr;
    end
  end

endmodule

// ===== hdl/slt_queue.sv =====
// ----------------------------------------------------------------------------
// slt_queue
// short queue of result groups between the lexer front and the issue stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  slt_pkg::bundle_t bundle_i,
  output logic             full_o,
  input  logic             pop_i,
  output slt_pkg::bundle_t head_o,
  output logic             empty_o
);

  localparam int PTRW = slt_pkg::QPTR_W;
  localparam int CNTW = slt_pkg::QCNT_W;

  slt_pkg::bundle_t mem_r [slt_pkg::QDEPTH];
  logic [PTRW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CNTW'(slt_pkg::QDEPTH));
  assign empty_o = (cnt_r == CNTW'(0));
  assign head_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= bundle_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(slt_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(slt_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + CNTW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNTW'(1);
    end
  end

  `CHK_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNTW'(slt_pkg::QDEPTH))
  `CHK_IMPLY(a_push_room, clk, rst_n, push_i, !full_o)

endmodule

// ===== hdl/slt_back.sv =====
// ----------------------------------------------------------------------------
// slt_back
// issue stage: walks each result group and hands results out one per transfer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  slt_pkg::bundle_t q_head_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic             out_pop_i,
  output logic             out_valid_o,
  output slt_pkg::res_t    out_res_o
);

  localparam int IW = slt_pkg::RES_IDX_W;
  localparam int NW = slt_pkg::RES_CNT_W;

  logic [IW-1:0] idx_r;
  logic          out_valid_r;
  slt_pkg::res_t out_r;
  logic          adv, head_last;

  // load the output register when it is free or being drained this cycle
  assign adv       = !q_empty_i && (!out_valid_r || out_pop_i);
  assign head_last = (NW'(idx_r) == q_head_i.cnt - NW'(1));
  assign q_pop_o   = adv && head_last;

  always_ff @(posedge clk) begin
    if (adv) out_r <= q_head_i.res[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      idx_r       <= head_last ? '0 : idx_r + IW'(1);
    end else if (out_pop_i) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_res_o   = out_r;

  `CHK_IMPLY(a_group_nonempty, clk, rst_n, !q_empty_i, q_head_i.cnt != NW'(0))
  `CHK_IMPLY(a_idx_in_group, clk, rst_n, !q_empty_i, NW'(idx_r) < q_head_i.cnt)
  `CHK_IMPLY(a_group_end_flag, clk, rst_n, adv && head_last, q_head_i.res[idx_r].last_of_run)

endmodule

// ===== hdl/shell_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// streaming lexer for one shell command line, token descriptors out
// ----------------------------------------------------------------------------
// Bytes enter one per cycle whenever in_full is low; end of line is an item of its
// own with in_end_of_line set. Each item yields zero to three results, grouped and
// placed in a four-entry group queue by the lexer front at the edge of the
// transfer; the issue stage then drains the queue into the output register, one
// result per cycle unless a full output register waits for out_pop; a result goes
// through a queue entry and then the output register. Input throughput is one byte
// per cycle as long as results are popped at least as fast as they are produced;
// the output register and its one-result-per-cycle drain set the sustained rate when
// bytes close several tokens at once. Offsets and lengths wrap to 12 and 13 bits.
module shell_line_tokenizer #(
  parameter int MAX_TOKENS = slt_pkg::MAX_TOKENS_DEF,
  parameter int MAX_LINE   = slt_pkg::MAX_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_character,
  input  logic        in_end_of_line,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_token_kind,
  output logic [11:0] out_token_start,
  output logic [12:0] out_token_length,
  output logic [1:0]  out_error_code,
  output logic        out_line_done,
  output logic        out_last_of_run
);

  logic             take, f_push, q_full, q_empty, q_pop, out_valid;
  slt_pkg::bundle_t f_bundle, q_head;
  slt_pkg::res_t    out_res;

  assign take    = in_push && !q_full;
  assign in_full = q_full;

  slt_front #(
    .MAX_TOKENS(MAX_TOKENS),
    .MAX_LINE  (MAX_LINE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take_i       (take),
    .character_i  (in_character),
    .end_of_line_i(in_end_of_line),
    .push_o       (f_push),
    .bundle_o     (f_bundle)
  );

  slt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .bundle_i(f_bundle),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  slt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head_i   (q_head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .out_pop_i  (out_pop && out_valid),
    .out_valid_o(out_valid),
    .out_res_o  (out_res)
  );

  assign out_empty        = !out_valid;
  assign out_token_kind   = 3'(out_res.kind);
  assign out_token_start  = out_res.start;
  assign out_token_length = out_res.len;
  assign out_error_code   = 2'(out_res.err);
  assign out_line_done    = out_res.line_done;
  assign out_last_of_run  = out_res.last_of_run;

endmodule

// ===== tb/tb_shell_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_shell_line_tokenizer
// self-checking bench for the streaming command line lexer: a directed table,
// token overflow corner lines, then random command lines with random gaps on
// both sides, checked against a cycle-free lexer model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_shell_line_tokenizer;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic [7:0]      chr;
    logic            eol;
    logic            typed;
    slt_pkg::kind_t  kind;
    slt_pkg::err_t   err;
    logic            done;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_character;
  logic        in_end_of_line;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_token_kind;
  logic [11:0] out_token_start;
  logic [12:0] out_token_length;
  logic [1:0]  out_error_code;
  logic        out_line_done;
  logic        out_last_of_run;

  // lexer model state
  int unsigned      lx_pos;
  int unsigned      lx_begin;
  int unsigned      lx_count;
  slt_pkg::mode_t   lx_mode;
  slt_pkg::redir_t  lx_redir;
  logic             lx_dq;
  slt_pkg::kind_t   prv_kind;
  slt_pkg::err_t    lx_err;

  slt_pkg::res_t    step_res [$];
  slt_pkg::res_t    exp_tokens [$];
  logic [7:0]       line_buf [$];

  int  idle_pct = 21;
  bit  hold_off = 1'b0;
  bit  press_go = 1'b0;
  int  n_items, n_lines, n_live, n_checked, n_bad, n_hold, cycles;
  int  n_err [4];

  logic [7:0] specials [6] = '{slt_pkg::CH_SPACE, slt_pkg::CH_PIPE, slt_pkg::CH_LT,
                               slt_pkg::CH_GT, slt_pkg::CH_SQUOTE, slt_pkg::CH_DQUOTE};

  // typed rows carry the single result they must give
  dir_row_t dir_rows [30] = '{
    '{8'h00,             1'b1, 1'b1, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b1},
    '{slt_pkg::CH_PIPE,   1'b0, 1'b1, slt_pkg::KIND_NONE, slt_pkg::ERR_SYNTAX, 1'b0},
    '{"x",               1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{8'hFF,             1'b1, 1'b1, slt_pkg::KIND_NONE, slt_pkg::ERR_SYNTAX, 1'b1},
    '{8'h00,             1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{8'hFF,             1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{8'h09,             1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_SPACE,  1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_LT,     1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_LT,     1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{"f",               1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_GT,     1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_GT,     1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{"g",               1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_PIPE,   1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_DQUOTE, 1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_SQUOTE, 1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_DQUOTE, 1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_LT,     1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{"h",               1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_PIPE,   1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_GT,     1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{8'h41,             1'b1, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_GT,     1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_SPACE,  1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{slt_pkg::CH_LT,     1'b0, 1'b1, slt_pkg::KIND_NONE, slt_pkg::ERR_SYNTAX, 1'b0},
    '{8'h00,             1'b1, 1'b1, slt_pkg::KIND_NONE, slt_pkg::ERR_SYNTAX, 1'b1},
    '{slt_pkg::CH_SQUOTE, 1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{"a",               1'b0, 1'b0, slt_pkg::KIND_NONE, slt_pkg::ERR_NONE,   1'b0},
    '{8'h7F,             1'b1, 1'b1, slt_pkg::KIND_NONE, slt_pkg::ERR_SYNTAX, 1'b1}
  };

  shell_line_tokenizer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_character     (in_character),
    .in_end_of_line   (in_end_of_line),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_error_code   (out_error_code),
    .out_line_done    (out_line_done),
    .out_last_of_run  (out_last_of_run)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- lexer model

  function automatic void put_res(slt_pkg::kind_t k, int unsigned st, int unsigned ln,
                                  slt_pkg::err_t e);
    slt_pkg::res_t r;
    if (step_res.size() >= slt_pkg::RES_MAX) return;
    r.kind = k;
    r.start = slt_pkg::START_W'(st);
    r.len = slt_pkg::LEN_W'(ln);
    r.err = e;
    r.line_done = 1'b0;
    r.last_of_run = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void raise_err(slt_pkg::err_t e);
    put_res(slt_pkg::KIND_NONE, 0, 0, e);
    lx_mode = slt_pkg::MODE_ERROR;
    lx_err = e;
  endfunction

  function automatic bit issue(slt_pkg::kind_t k, int unsigned st, int unsigned ln);
    if (lx_count >= slt_pkg::MAX_TOKENS_DEF) begin
      raise_err(slt_pkg::ERR_TOKENS);
      return 1'b0;
    end
    put_res(k, st, ln, slt_pkg::ERR_NONE);
    lx_count++;
    prv_kind = k;
    return 1'b1;
  endfunction

  function automatic bit close_word();
    if (lx_pos > lx_begin) return issue(slt_pkg::KIND_WORD, lx_begin, lx_pos - lx_begin);
    return 1'b1;
  endfunction

  function automatic bit is_redir(slt_pkg::kind_t k);
    return k >= slt_pkg::KIND_IN && k <= slt_pkg::KIND_APPEND;
  endfunction

  function automatic void clear_line();
    lx_pos = 0;
    lx_begin = 0;
    lx_count = 0;
    lx_mode = slt_pkg::MODE_NORMAL;
    lx_redir = slt_pkg::RED_NONE;
    lx_dq = 1'b0;
    prv_kind = slt_pkg::KIND_NONE;
    lx_err = slt_pkg::ERR_NONE;
  endfunction

  // normal mode with no redirect waiting
  function automatic void plain_byte(logic [7:0] c);
    if (c == slt_pkg::CH_SPACE) begin
      if (!close_word()) return;
      lx_begin = lx_pos + 1;
    end else if (c == slt_pkg::CH_PIPE) begin
      if (!close_word()) return;
      if (prv_kind == slt_pkg::KIND_NONE || prv_kind == slt_pkg::KIND_PIPE ||
          prv_kind == slt_pkg::KIND_IN || prv_kind == slt_pkg::KIND_HEREDOC) begin
        raise_err(slt_pkg::ERR_SYNTAX);
        return;
      end
      if (!issue(slt_pkg::KIND_PIPE, lx_pos, 1)) return;
      lx_begin = lx_pos + 1;
    end else if (c == slt_pkg::CH_SQUOTE || c == slt_pkg::CH_DQUOTE) begin
      lx_mode = slt_pkg::MODE_QUOTE;
      lx_dq = (c == slt_pkg::CH_DQUOTE);
    end else if (c == slt_pkg::CH_LT || c == slt_pkg::CH_GT) begin
      if (!close_word()) return;
      if (is_redir(prv_kind)) begin
        raise_err(slt_pkg::ERR_SYNTAX);
        return;
      end
      lx_redir = (c == slt_pkg::CH_LT) ? slt_pkg::RED_IN : slt_pkg::RED_OUT;
      lx_begin = lx_pos;
    end
  endfunction

  function automatic void lex_char(logic [7:0] c);
    bit in_side;
    if (lx_mode == slt_pkg::MODE_ERROR) return;
    if (lx_pos >= slt_pkg::MAX_LINE_DEF) begin
      raise_err(slt_pkg::ERR_LONG);
      return;
    end
    if (lx_mode == slt_pkg::MODE_QUOTE) begin
      if (c == (lx_dq ? slt_pkg::CH_DQUOTE : slt_pkg::CH_SQUOTE)) begin
        if (issue(slt_pkg::KIND_QUOTED, lx_begin, lx_pos + 1 - lx_begin)) begin
          lx_mode = slt_pkg::MODE_NORMAL;
          lx_begin = lx_pos + 1;
        end
      end
    end else if (lx_redir != slt_pkg::RED_NONE) begin
      in_side = (lx_redir == slt_pkg::RED_IN);
      lx_redir = slt_pkg::RED_NONE;
      if (c == (in_side ? slt_pkg::CH_LT : slt_pkg::CH_GT)) begin
        if (issue(in_side ? slt_pkg::KIND_HEREDOC : slt_pkg::KIND_APPEND, lx_begin, 2))
          lx_begin = lx_pos + 1;
      end else if (issue(in_side ? slt_pkg::KIND_IN : slt_pkg::KIND_OUT, lx_begin, 1)) begin
        lx_begin = lx_pos;
        plain_byte(c);
      end
    end else begin
      plain_byte(c);
    end
    lx_pos++;
  endfunction

  function automatic void lex_eol();
    bit ok;
    if (lx_mode == slt_pkg::MODE_ERROR) begin
      put_res(slt_pkg::KIND_NONE, 0, 0, lx_err);
    end else if (lx_mode == slt_pkg::MODE_QUOTE) begin
      raise_err(slt_pkg::ERR_SYNTAX);
    end else begin
      if (lx_redir != slt_pkg::RED_NONE) begin
        ok = issue(lx_redir == slt_pkg::RED_IN ? slt_pkg::KIND_IN : slt_pkg::KIND_OUT,
                   lx_begin, 1);
        lx_redir = slt_pkg::RED_NONE;
      end else begin
        ok = close_word();
      end
      if (ok && (prv_kind == slt_pkg::KIND_PIPE || is_redir(prv_kind)))
        raise_err(slt_pkg::ERR_SYNTAX);
    end
    if (step_res.size() == 0) put_res(slt_pkg::KIND_NONE, 0, 0, slt_pkg::ERR_NONE);
    step_res[step_res.size() - 1].line_done = 1'b1;
    clear_line();
  endfunction

  function automatic void lex_step(logic [7:0] c, logic eol);
    step_res.delete();
    if (eol) lex_eol();
    else lex_char(c);
    if (step_res.size() > 0) step_res[step_res.size() - 1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------- line builders

  function automatic logic [7:0] letter();
    return 8'(8'h61 + $urandom_range(25));
  endfunction

  function automatic void add_gap();
    repeat ($urandom_range(2, 1)) line_buf.push_back(slt_pkg::CH_SPACE);
  endfunction

  function automatic void add_word();
    int n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: line_buf.push_back(8'h09);
        1: line_buf.push_back(8'h00);
        2: line_buf.push_back(8'hFF);
        3: line_buf.push_back(8'($urandom_range(255)));
        default: line_buf.push_back(letter());
      endcase
    end
  endfunction

  function automatic void add_quoted();
    logic [7:0] q = $urandom_range(1) ? slt_pkg::CH_DQUOTE : slt_pkg::CH_SQUOTE;
    int n = $urandom_range(3);
    if ($urandom_range(1)) add_word();
    line_buf.push_back(q);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: line_buf.push_back(q == slt_pkg::CH_DQUOTE ? slt_pkg::CH_SQUOTE
                                                      : slt_pkg::CH_DQUOTE);
        1: line_buf.push_back(slt_pkg::CH_SPACE);
        default: line_buf.push_back(letter());
      endcase
    end
    line_buf.push_back(q);
  endfunction

  function automatic void add_redirect();
    case ($urandom_range(3))
      0: line_buf.push_back(slt_pkg::CH_LT);
      1: line_buf.push_back(slt_pkg::CH_GT);
      2: begin
        line_buf.push_back(slt_pkg::CH_LT);
        line_buf.push_back(slt_pkg::CH_LT);
      end
      default: begin
        line_buf.push_back(slt_pkg::CH_GT);
        line_buf.push_back(slt_pkg::CH_GT);
      end
    endcase
    if ($urandom_range(1)) line_buf.push_back(slt_pkg::CH_SPACE);
    add_word();
  endfunction

  function automatic void add_command();
    int nargs = $urandom_range(3, 1);
    for (int a = 0; a < nargs; a++) begin
      if (a > 0) add_gap();
      if ($urandom_range(3) == 0) add_quoted();
      else add_word();
    end
    if ($urandom_range(9) < 3) begin
      if ($urandom_range(1)) add_gap();
      add_redirect();
    end
  endfunction

  // mostly well formed pipelines, some broken ones, some plain noise
  function automatic void gen_line();
    int ncmd = $urandom_range(3, 1);
    int nbytes = $urandom_range(12, 1);
    int keep;
    line_buf.delete();
    if ($urandom_range(9) == 0) begin
      repeat (nbytes)
        line_buf.push_back($urandom_range(1) ? 8'($urandom_range(255))
                                              : specials[$urandom_range(5)]);
      return;
    end
    if ($urandom_range(3) == 0) line_buf.push_back(slt_pkg::CH_SPACE);
    for (int c = 0; c < ncmd; c++) begin
      if (c > 0) begin
        if ($urandom_range(1)) add_gap();
        line_buf.push_back(slt_pkg::CH_PIPE);
        if ($urandom_range(1)) add_gap();
      end
      add_command();
    end
    case ($urandom_range(9))
      0: line_buf.insert($urandom_range(line_buf.size()), specials[$urandom_range(5)]);
      1: begin
        keep = $urandom_range(line_buf.size() - 1);
        while (line_buf.size() > keep) void'(line_buf.pop_back());
      end
      2: line_buf.push_back(specials[$urandom_range(5, 1)]);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic [7:0] chr, input logic eol, input bit typed,
                           input slt_pkg::res_t typ);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_character <= chr;
    in_end_of_line <= eol;
    @(posedge clk);
    while (in_full) @(posedge clk);
    // transfer taken at this edge
    if (eol || lx_mode != slt_pkg::MODE_ERROR) n_live++;
    lex_step(chr, eol);
    if (typed) exp_tokens.push_back(typ);
    else foreach (step_res[i]) exp_tokens.push_back(step_res[i]);
    n_items++;
    if (eol) n_lines++;
  endtask

  task automatic send_line();
    slt_pkg::res_t none_res = '0;
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0, 1'b0, none_res);
    send_item(8'($urandom_range(255)), 1'b1, 1'b0, none_res);
  endtask

  // result side: random pops, checked against the oldest expectation
  always @(posedge clk) begin
    slt_pkg::res_t got, want;
    if (rst_n && out_pop && !out_empty) begin
      got = {out_token_kind, out_token_start, out_token_length, out_error_code,
             out_line_done, out_last_of_run};
      n_checked++;
      n_err[got.err]++;
      if (exp_tokens.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: kind %0d start %0d len %0d err %0d done %0d last %0d",
                   got.kind, got.start, got.len, got.err, got.line_done, got.last_of_run);
      end else begin
        want = exp_tokens.pop_front();
        if (got.kind !== want.kind || got.start !== want.start || got.len !== want.len ||
            got.err !== want.err || got.line_done !== want.line_done ||
            got.last_of_run !== want.last_of_run) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch at result %0d: exp kind %0d start %0d len %0d err %0d",
                     n_checked, want.kind, want.start, want.len, want.err);
            $display("  exp done %0d last %0d, got kind %0d start %0d len %0d err %0d",
                     want.line_done, want.last_of_run, got.kind, got.start, got.len,
                     got.err);
            $display("  got done %0d last %0d", got.line_done, got.last_of_run);
          end
        end
      end
    end
    out_pop <= rst_n && !hold_off && ($urandom_range(99) >= idle_pct);
  end

  // long receiver stall so the result queue fills and in_full rises
  initial begin
    wait (press_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) begin
      @(posedge clk);
      n_hold++;
    end
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               exp_tokens.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    slt_pkg::res_t row_res;
    int            live_goal;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_character = 8'h00;
    in_end_of_line = 1'b0;
    clear_line();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row_res = '{kind: dir_rows[i].kind, start: '0, len: '0, err: dir_rows[i].err,
                  line_done: dir_rows[i].done, last_of_run: 1'b1};
      send_item(dir_rows[i].chr, dir_rows[i].eol, dir_rows[i].typed, row_res);
    end

    // one token past the per-line limit
    repeat (2) begin
      line_buf.delete();
      repeat (slt_pkg::MAX_TOKENS_DEF) begin
        line_buf.push_back(letter());
        line_buf.push_back(slt_pkg::CH_SPACE);
      end
      case ($urandom_range(3))
        0: add_word();
        1: line_buf.push_back(slt_pkg::CH_PIPE);
        2: add_redirect();
        default: add_quoted();
      endcase
      send_line();
    end

    press_go = 1'b1;
    live_goal = n_live + RANDOM_ITEMS;
    while (n_live < live_goal) begin
      // quiet stretch with no gaps on either side
      idle_pct = (n_live > live_goal - 80 && n_live < live_goal - 20) ? 0 : 21;
      gen_line();
      send_line();
    end
    in_push <= 1'b0;

    while (exp_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d bytes and ends of line over %0d lines, %0d results checked", n_items,
             n_lines, n_checked);
    $display("error reports: syntax %0d, token overflow %0d, too long %0d; %0d stalls",
             n_err[slt_pkg::ERR_SYNTAX], n_err[slt_pkg::ERR_TOKENS],
             n_err[slt_pkg::ERR_LONG], n_hold);
    if (n_bad == 0 && exp_tokens.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/slt_pkg.sv
hdl/slt_front.sv
hdl/slt_queue.sv
hdl/slt_back.sv
hdl/shell_line_tokenizer.sv
tb/tb_shell_line_tokenizer.sv
